FILE: rtl/core/pdl_pkg.sv
// Shared types, codes and widths for the driver pedal-switch block.
package pdl_pkg;

	// fixed field widths
	localparam int ACCEL_W        = 17;
	localparam int STEP_W         = 16;
	localparam int TIME_PORT_W    = 20;
	localparam int TIME_WIDTH_DEF = 20;
	localparam int APB_AW         = 3;
	localparam int APB_DW         = 32;

	// register indexes, selected by paddr[2]
	localparam logic REG_RESIST = 1'b0;
	localparam logic REG_STEP   = 1'b1;

	// register reset values
	localparam logic signed [ACCEL_W-1:0] RESIST_RST = '0;
	localparam logic [STEP_W-1:0]         STEP_RST   = 16'd102;

	typedef enum logic [1:0] {
		FOOT_ACCEL = 2'd0,
		FOOT_BRAKE = 2'd1,
		FOOT_FREE  = 2'd2
	} foot_t;

	typedef enum logic [2:0] {
		ST_NO_CHANGE  = 3'd0,
		ST_CHANGING   = 3'd1,
		ST_CHANGED    = 3'd2,
		ST_IMMEDIATE  = 3'd3,
		ST_PLAN_DONE  = 3'd4
	} status_t;

	typedef enum logic {
		ACT_PLAN    = 1'b0,
		ACT_EXECUTE = 1'b1
	} action_t;

	// configuration register contents
	typedef struct packed {
		logic signed [ACCEL_W-1:0] accel_resistance;
		logic [STEP_W-1:0]         time_step;
	} pdl_cfg_t;

	// control part of the pedal state
	typedef struct packed {
		foot_t foot;
		foot_t target;
		logic  changing;
	} pdl_ctrl_t;

endpackage

FILE: rtl/core/pdl_cfg.sv
// APB-style configuration registers for the pedal-switch block.
module pdl_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pdl_pkg::APB_AW-1:0]     paddr,
	input  logic [pdl_pkg::APB_DW-1:0]     pwdata,
	output logic [pdl_pkg::APB_DW-1:0]     prdata,
	output logic                           pready,
	output pdl_pkg::pdl_cfg_t              cfg
);
	import pdl_pkg::*;

	pdl_cfg_t cfg_q;
	logic     wr_en;
	logic     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	// write the selected register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_resistance <= RESIST_RST;
			cfg_q.time_step        <= STEP_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_RESIST: cfg_q.accel_resistance <= signed'(pwdata[ACCEL_W-1:0]);
				REG_STEP:   cfg_q.time_step        <= pwdata[STEP_W-1:0];
				default:    cfg_q.time_step        <= cfg_q.time_step;
			endcase
		end
	end

	// return the register value, resistance sign-extended
	always_comb begin
		case (reg_sel)
			REG_RESIST: prdata = APB_DW'(cfg_q.accel_resistance);
			REG_STEP:   prdata = APB_DW'(cfg_q.time_step);
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/pdl_step.sv
// Next-state logic of the pedal switch: plan and execute for one transaction.
module pdl_step #(
	parameter int TIME_WIDTH = pdl_pkg::TIME_WIDTH_DEF
) (
	input  pdl_pkg::pdl_cfg_t                    cfg,
	input  logic                                 action,
	input  logic signed [pdl_pkg::ACCEL_W-1:0]   next_accel,
	input  logic [pdl_pkg::TIME_PORT_W-1:0]      accel_to_brake_time,
	input  logic [pdl_pkg::TIME_PORT_W-1:0]      brake_to_accel_time,
	input  logic                                 recognition_hit,
	input  pdl_pkg::pdl_ctrl_t                   ctrl_cur,
	input  logic [TIME_WIDTH-1:0]                elapsed_cur,
	input  logic [TIME_WIDTH-1:0]                needed_cur,
	output pdl_pkg::pdl_ctrl_t                   ctrl_nxt,
	output logic [TIME_WIDTH-1:0]                elapsed_nxt,
	output logic [TIME_WIDTH-1:0]                needed_nxt,
	output pdl_pkg::status_t                     status
);
	import pdl_pkg::*;

	localparam int CW = (TIME_WIDTH > TIME_PORT_W) ? TIME_WIDTH : TIME_PORT_W;
	localparam int SW = ((TIME_WIDTH > STEP_W) ? TIME_WIDTH : STEP_W) + 1;

	logic [TIME_WIDTH-1:0]     tmax;
	logic [CW-1:0]             tmax_c;
	logic [CW-1:0]             a2b_c;
	logic [CW-1:0]             b2a_c;
	logic [TIME_WIDTH-1:0]     a2b;
	logic [TIME_WIDTH-1:0]     b2a;
	logic [SW-1:0]             el_sum;
	logic [TIME_WIDTH-1:0]     el_grown;
	logic signed [ACCEL_W:0]   margin;
	logic                      gt;
	logic                      lt;
	logic                      keep;
	logic                      opp;
	foot_t                     want;
	foot_t                     other;
	logic [TIME_WIDTH-1:0]     full;

	// saturate the incoming times to the time width
	assign tmax   = '1;
	assign tmax_c = CW'(tmax);
	assign a2b_c  = CW'(accel_to_brake_time);
	assign b2a_c  = CW'(brake_to_accel_time);
	assign a2b    = (a2b_c > tmax_c) ? tmax : a2b_c[TIME_WIDTH-1:0];
	assign b2a    = (b2a_c > tmax_c) ? tmax : b2a_c[TIME_WIDTH-1:0];

	// grow the elapsed time while switching, saturating
	assign el_sum   = SW'(elapsed_cur) + SW'(cfg.time_step);
	assign el_grown = !ctrl_cur.changing ? elapsed_cur :
		(el_sum > SW'(tmax)) ? tmax : el_sum[TIME_WIDTH-1:0];

	// compare against minus the resistance: next + resistance against zero
	assign margin = {next_accel[ACCEL_W-1], next_accel}
		+ {cfg.accel_resistance[ACCEL_W-1], cfg.accel_resistance};
	assign lt     = margin[ACCEL_W];
	assign gt     = !margin[ACCEL_W] && (margin != '0);

	assign keep  = (ctrl_cur.foot == FOOT_ACCEL) ? gt : lt;
	assign opp   = (ctrl_cur.foot == FOOT_ACCEL) ? lt : gt;
	assign want  = gt ? FOOT_ACCEL : FOOT_BRAKE;
	assign other = gt ? FOOT_BRAKE : FOOT_ACCEL;
	assign full  = gt ? b2a : a2b;

	always_comb begin
		ctrl_nxt    = ctrl_cur;
		elapsed_nxt = elapsed_cur;
		needed_nxt  = needed_cur;
		status      = ST_NO_CHANGE;
		if (action == ACT_PLAN) begin
			status      = ST_PLAN_DONE;
			elapsed_nxt = el_grown;
			case (ctrl_cur.foot)
				FOOT_ACCEL, FOOT_BRAKE: begin
					if (keep) begin
						ctrl_nxt.changing = 1'b0;
						elapsed_nxt       = '0;
						ctrl_nxt.target   = ctrl_cur.foot;
					end else if (opp) begin
						ctrl_nxt.changing = 1'b1;
						needed_nxt        = (ctrl_cur.foot == FOOT_ACCEL) ? a2b : b2a;
						ctrl_nxt.target   = (ctrl_cur.foot == FOOT_ACCEL) ?
							FOOT_BRAKE : FOOT_ACCEL;
					end else begin
						ctrl_nxt.changing = 1'b1;
						needed_nxt        = '0;
						ctrl_nxt.target   = FOOT_FREE;
					end
				end
				FOOT_FREE: begin
					if (!gt && !lt) begin
						ctrl_nxt.changing = 1'b0;
						elapsed_nxt       = '0;
						ctrl_nxt.target   = FOOT_FREE;
					end else if (ctrl_cur.target != want) begin
						// reverse a half-done switch or start from free
						if (ctrl_cur.target == other) begin
							needed_nxt = (el_grown < full) ? el_grown : full;
						end else if (ctrl_cur.target == FOOT_FREE) begin
							needed_nxt = full >> 1;
						end
						ctrl_nxt.changing = 1'b1;
						elapsed_nxt       = '0;
						ctrl_nxt.target   = want;
					end
				end
				default: begin
					ctrl_nxt = ctrl_cur;
				end
			endcase
		end else begin
			if (ctrl_cur.changing) begin
				if (elapsed_cur >= needed_cur) begin
					ctrl_nxt.changing = 1'b0;
					elapsed_nxt       = '0;
					ctrl_nxt.foot     = ctrl_cur.target;
					status            = ST_CHANGED;
				end else begin
					ctrl_nxt.foot = FOOT_FREE;
					status        = ST_CHANGING;
				end
			end else if (recognition_hit) begin
				ctrl_nxt.changing = 1'b0;
				elapsed_nxt       = '0;
				ctrl_nxt.foot     = ctrl_cur.target;
				status            = ST_IMMEDIATE;
			end
		end
	end

endmodule

FILE: rtl/core/driver_pedal_switch_fsm.sv
// Top level of the driver pedal-switch block: input register, state, result register.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | action, next_accel, *_time, recognition_hit
//  out     | out_valid / out_stall| status, foot_now, foot_target, switching, times
//  cfg     | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle unless the output stalls; the result is registered.
// The plan/execute logic runs between the input register and the result register,
// with the pedal state updated in the same cycle the result register loads.
// Reset puts the foot and target free, clears the switch flag and both times.
// A stalled output holds the result and stalls the input once the input register fills.
module driver_pedal_switch_fsm #(
	parameter int TIME_WIDTH = pdl_pkg::TIME_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pdl_pkg::APB_AW-1:0]           paddr,
	input  logic [pdl_pkg::APB_DW-1:0]           pwdata,
	output logic [pdl_pkg::APB_DW-1:0]           prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic signed [pdl_pkg::ACCEL_W-1:0]   next_accel,
	input  logic [pdl_pkg::TIME_PORT_W-1:0]      accel_to_brake_time,
	input  logic [pdl_pkg::TIME_PORT_W-1:0]      brake_to_accel_time,
	input  logic                                 recognition_hit,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [2:0]                           status,
	output logic [1:0]                           foot_now,
	output logic [1:0]                           foot_target,
	output logic                                 switching,
	output logic [pdl_pkg::TIME_PORT_W-1:0]      time_spent,
	output logic [pdl_pkg::TIME_PORT_W-1:0]      time_required
);
	import pdl_pkg::*;

	localparam int CW = (TIME_WIDTH > TIME_PORT_W) ? TIME_WIDTH : TIME_PORT_W;

	pdl_cfg_t                  cfg;

	logic                      valid_s1;
	logic                      action_s1;
	logic signed [ACCEL_W-1:0] next_accel_s1;
	logic [TIME_PORT_W-1:0]    a2b_s1;
	logic [TIME_PORT_W-1:0]    b2a_s1;
	logic                      hit_s1;

	pdl_ctrl_t                 ctrl_q;
	logic [TIME_WIDTH-1:0]     elapsed_q;
	logic [TIME_WIDTH-1:0]     needed_q;

	pdl_ctrl_t                 ctrl_nxt;
	logic [TIME_WIDTH-1:0]     elapsed_nxt;
	logic [TIME_WIDTH-1:0]     needed_nxt;
	status_t                   status_nxt;
	logic [CW-1:0]             elapsed_ext;
	logic [CW-1:0]             needed_ext;

	logic                      out_valid_q;
	logic [2:0]                status_q;
	logic [1:0]                foot_now_q;
	logic [1:0]                foot_target_q;
	logic                      switching_q;
	logic [TIME_PORT_W-1:0]    time_spent_q;
	logic [TIME_PORT_W-1:0]    time_required_q;

	logic                      advance;
	logic                      fire;
	logic                      in_take;

	pdl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pdl_step #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_step (
		.cfg                 (cfg),
		.action              (action_s1),
		.next_accel          (next_accel_s1),
		.accel_to_brake_time (a2b_s1),
		.brake_to_accel_time (b2a_s1),
		.recognition_hit     (hit_s1),
		.ctrl_cur            (ctrl_q),
		.elapsed_cur         (elapsed_q),
		.needed_cur          (needed_q),
		.ctrl_nxt            (ctrl_nxt),
		.elapsed_nxt         (elapsed_nxt),
		.needed_nxt          (needed_nxt),
		.status              (status_nxt)
	);

	// handshake: the result register frees up when empty or taken
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// hold the accepted transaction in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1     <= action;
			next_accel_s1 <= next_accel;
			a2b_s1        <= accel_to_brake_time;
			b2a_s1        <= brake_to_accel_time;
			hit_s1        <= recognition_hit;
		end
	end

	// advance the pedal state once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.foot     <= FOOT_FREE;
			ctrl_q.target   <= FOOT_FREE;
			ctrl_q.changing <= 1'b0;
			elapsed_q       <= '0;
			needed_q        <= '0;
		end else if (fire) begin
			ctrl_q    <= ctrl_nxt;
			elapsed_q <= elapsed_nxt;
			needed_q  <= needed_nxt;
		end
	end

	assign elapsed_ext = CW'(elapsed_nxt);
	assign needed_ext  = CW'(needed_nxt);

	// load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q        <= status_nxt;
			foot_now_q      <= ctrl_nxt.foot;
			foot_target_q   <= ctrl_nxt.target;
			switching_q     <= ctrl_nxt.changing;
			time_spent_q    <= elapsed_ext[TIME_PORT_W-1:0];
			time_required_q <= needed_ext[TIME_PORT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign foot_now      = foot_now_q;
	assign foot_target   = foot_target_q;
	assign switching     = switching_q;
	assign time_spent    = time_spent_q;
	assign time_required = time_required_q;

endmodule

FILE: dv/driver_pedal_switch_fsm_tb.sv
// Self-checking testbench for the driver pedal-switch block: directed table, then random bursts.
`timescale 1ns / 1ps

module driver_pedal_switch_fsm_tb;
	import pdl_pkg::*;

	localparam int PHASE_ITEMS    = 84;
	localparam int NUM_PHASES     = 7;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int IDLE_PCT       = 12;

	// one input transaction
	typedef struct packed {
		action_t                   action;
		logic signed [ACCEL_W-1:0] accel;
		logic [TIME_PORT_W-1:0]    a2b;
		logic [TIME_PORT_W-1:0]    b2a;
		logic                      hit;
	} pedal_in_t;

	// one result transaction
	typedef struct packed {
		status_t                status;
		foot_t                  foot_now;
		foot_t                  foot_target;
		logic                   switching;
		logic [TIME_PORT_W-1:0] spent;
		logic [TIME_PORT_W-1:0] required;
	} pedal_res_t;

	// directed row: stimulus plus an optional hand-written result
	typedef struct packed {
		pedal_in_t  stim;
		logic       typed;
		pedal_res_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic action;
	logic signed [ACCEL_W-1:0] next_accel;
	logic [TIME_PORT_W-1:0] accel_to_brake_time;
	logic [TIME_PORT_W-1:0] brake_to_accel_time;
	logic recognition_hit;
	logic out_valid;
	logic out_stall;
	logic [2:0] status;
	logic [1:0] foot_now;
	logic [1:0] foot_target;
	logic switching;
	logic [TIME_PORT_W-1:0] time_spent;
	logic [TIME_PORT_W-1:0] time_required;

	// hand-written result travels with the payload
	logic       row_typed;
	pedal_res_t row_want;

	// predicted pedal state and register copies
	foot_t                  mdl_foot;
	foot_t                  mdl_target;
	logic                   mdl_switching;
	logic [TIME_PORT_W-1:0] mdl_spent;
	logic [TIME_PORT_W-1:0] mdl_required;
	int                     cfg_resist;
	int                     cfg_step;

	pedal_res_t pending_q[$];
	dir_row_t   dir_tab[$];
	int         err_count = 0;
	int         res_idx = 0;
	int         idle_cycles = 0;
	bit         quiet = 1'b0;

	driver_pedal_switch_fsm dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.action              (action),
		.next_accel          (next_accel),
		.accel_to_brake_time (accel_to_brake_time),
		.brake_to_accel_time (brake_to_accel_time),
		.recognition_hit     (recognition_hit),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.foot_now            (foot_now),
		.foot_target         (foot_target),
		.switching           (switching),
		.time_spent          (time_spent),
		.time_required       (time_required)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// advance the pedal state by one transaction and return its result
	function automatic pedal_res_t pedal_step(pedal_in_t it);
		int                     thr;
		int                     nxt;
		int                     cmp;
		int                     keep;
		logic [TIME_PORT_W:0]   sum;
		foot_t                  want;
		foot_t                  other;
		logic [TIME_PORT_W-1:0] full;
		pedal_res_t             r;
		if (it.action == ACT_PLAN) begin
			thr = -cfg_resist;
			nxt = $signed(it.accel);
			cmp = (nxt > thr) ? 1 : ((nxt < thr) ? -1 : 0);
			// grow elapsed time first, saturating
			if (mdl_switching) begin
				sum = {1'b0, mdl_spent} + (TIME_PORT_W + 1)'(cfg_step);
				mdl_spent = sum[TIME_PORT_W] ? '1 : sum[TIME_PORT_W-1:0];
			end
			if (mdl_foot == FOOT_ACCEL || mdl_foot == FOOT_BRAKE) begin
				keep = (mdl_foot == FOOT_ACCEL) ? 1 : -1;
				if (cmp == keep) begin
					mdl_switching = 1'b0;
					mdl_spent = '0;
					mdl_target = mdl_foot;
				end else begin
					mdl_switching = 1'b1;
					if (cmp == -keep) begin
						if (mdl_foot == FOOT_ACCEL) begin
							mdl_required = it.a2b;
							mdl_target = FOOT_BRAKE;
						end else begin
							mdl_required = it.b2a;
							mdl_target = FOOT_ACCEL;
						end
					end else begin
						mdl_required = '0;
						mdl_target = FOOT_FREE;
					end
				end
			end else if (mdl_foot == FOOT_FREE) begin
				if (cmp == 0) begin
					mdl_switching = 1'b0;
					mdl_spent = '0;
					mdl_target = FOOT_FREE;
				end else begin
					if (cmp > 0) begin
						want = FOOT_ACCEL;
						other = FOOT_BRAKE;
						full = it.b2a;
					end else begin
						want = FOOT_BRAKE;
						other = FOOT_ACCEL;
						full = it.a2b;
					end
					// reversing mid-switch reuses the time already spent
					if (mdl_target != want) begin
						if (mdl_target == other)
							mdl_required = (mdl_spent < full) ? mdl_spent : full;
						else if (mdl_target == FOOT_FREE)
							mdl_required = full >> 1;
						mdl_switching = 1'b1;
						mdl_spent = '0;
						mdl_target = want;
					end
				end
			end
			r.status = ST_PLAN_DONE;
		end else begin
			if (mdl_switching) begin
				if (mdl_spent >= mdl_required) begin
					mdl_switching = 1'b0;
					mdl_spent = '0;
					mdl_foot = mdl_target;
					r.status = ST_CHANGED;
				end else begin
					mdl_foot = FOOT_FREE;
					r.status = ST_CHANGING;
				end
			end else if (it.hit) begin
				mdl_switching = 1'b0;
				mdl_spent = '0;
				mdl_foot = mdl_target;
				r.status = ST_IMMEDIATE;
			end else begin
				r.status = ST_NO_CHANGE;
			end
		end
		r.foot_now = mdl_foot;
		r.foot_target = mdl_target;
		r.switching = mdl_switching;
		r.spent = mdl_spent;
		r.required = mdl_required;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch at result %0d: %s", $realtime, res_idx, msg);
		err_count++;
	endtask

	// append one directed row
	function automatic void add_row(action_t act, int accel, int a2b, int b2a, bit hit,
			bit typed, status_t st, foot_t fn, foot_t ft, bit sw, int sp, int rq);
		dir_row_t row;
		row.stim.action = act;
		row.stim.accel = ACCEL_W'(accel);
		row.stim.a2b = TIME_PORT_W'(a2b);
		row.stim.b2a = TIME_PORT_W'(b2a);
		row.stim.hit = hit;
		row.typed = typed;
		row.want.status = st;
		row.want.foot_now = fn;
		row.want.foot_target = ft;
		row.want.switching = sw;
		row.want.spent = TIME_PORT_W'(sp);
		row.want.required = TIME_PORT_W'(rq);
		dir_tab.push_back(row);
	endfunction

	// pick a switch time, mostly small so switches can complete
	function automatic logic [TIME_PORT_W-1:0] pick_time();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40)
			return TIME_PORT_W'($urandom_range(300));
		else if (sel < 70)
			return TIME_PORT_W'($urandom_range(5000));
		else if (sel < 90)
			return TIME_PORT_W'($urandom());
		else if (sel < 95)
			return '0;
		return '1;
	endfunction

	// pick an acceleration above (0), below (1) or at (2) the threshold
	function automatic logic signed [ACCEL_W-1:0] pick_accel(int dir);
		int thr;
		int val;
		thr = -cfg_resist;
		val = int'($signed(ACCEL_W'($urandom())));
		if (dir == 0 && thr < 65535) begin
			if ($urandom_range(1))
				val = thr + 1 + $urandom_range(7);
			else
				val = thr + 1 + $urandom_range(65535 - thr - 1);
			if (val > 65535)
				val = 65535;
		end else if (dir == 1 && thr > -65536) begin
			if ($urandom_range(1))
				val = thr - 1 - $urandom_range(7);
			else
				val = thr - 1 - $urandom_range(thr - 1 + 65536);
			if (val < -65536)
				val = -65536;
		end else if (dir == 2 && thr <= 65535) begin
			val = thr;
		end
		return ACCEL_W'(val);
	endfunction

	// present one transaction and hold it until accepted
	task automatic send_item(input pedal_in_t it, input logic typed, input pedal_res_t want);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.action;
		next_accel <= it.accel;
		accel_to_brake_time <= it.a2b;
		brake_to_accel_time <= it.b2a;
		recognition_hit <= it.hit;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// drop valid and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup, access, then return the bus to idle
	task automatic write_reg(input logic idx, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_RESIST)
			cfg_resist = value;
		else
			cfg_step = value;
		@(posedge clk);
	endtask

	// receiver: random stall except in quiet stretches
	always @(posedge clk) begin
		out_stall <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
	end

	// check results in order, predict each accepted transaction
	always @(posedge clk) begin
		pedal_res_t exp_r;
		pedal_res_t pred;
		pedal_in_t  got_in;
		if (arst_n) begin
			idle_cycles++;
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				idle_cycles = 0;
				if (pending_q.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					exp_r = pending_q.pop_front();
					if (status !== exp_r.status)
						report_mismatch($sformatf("status got %0d want %0d",
							status, exp_r.status));
					if (foot_now !== exp_r.foot_now)
						report_mismatch($sformatf("foot_now got %0d want %0d",
							foot_now, exp_r.foot_now));
					if (foot_target !== exp_r.foot_target)
						report_mismatch($sformatf("foot_target got %0d want %0d",
							foot_target, exp_r.foot_target));
					if (switching !== exp_r.switching)
						report_mismatch($sformatf("switching got %0d want %0d",
							switching, exp_r.switching));
					if (time_spent !== exp_r.spent)
						report_mismatch($sformatf("time_spent got %0d want %0d",
							time_spent, exp_r.spent));
					if (time_required !== exp_r.required)
						report_mismatch($sformatf("time_required got %0d want %0d",
							time_required, exp_r.required));
				end
				res_idx++;
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				idle_cycles = 0;
				got_in.action = action_t'(action);
				got_in.accel = next_accel;
				got_in.a2b = accel_to_brake_time;
				got_in.b2a = brake_to_accel_time;
				got_in.hit = recognition_hit;
				pred = pedal_step(got_in);
				pending_q.push_back(row_typed ? row_want : pred);
			end
		end
	end

	// end the run if nothing moves for too long
	initial begin
		do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		pedal_in_t  it;
		pedal_res_t none;
		int         phase_resist[NUM_PHASES];
		int         phase_step[NUM_PHASES];
		int         n;
		int         dir;
		int         plans;
		int         execs;
		bit         paused;

		// quiet inputs and reset
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		action <= 1'b0;
		next_accel <= '0;
		accel_to_brake_time <= '0;
		brake_to_accel_time <= '0;
		recognition_hit <= 1'b0;
		row_typed <= 1'b0;
		row_want <= '0;
		out_stall <= 1'b0;
		none = '0;
		paused = 1'b0;

		mdl_foot = FOOT_FREE;
		mdl_target = FOOT_FREE;
		mdl_switching = 1'b0;
		mdl_spent = '0;
		mdl_required = '0;
		cfg_resist = int'(RESIST_RST);
		cfg_step = int'(STEP_RST);

		// idle execute, neutral plan, then half-time switch from free
		add_row(ACT_EXECUTE, 0, 0, 0, 0, 1, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_PLAN, 0, 0, 0, 1, 1, ST_PLAN_DONE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_PLAN, 65535, 7, 1048575, 0, 1,
			ST_PLAN_DONE, FOOT_FREE, FOOT_ACCEL, 1, 0, 524287);
		add_row(ACT_PLAN, 65535, 7, 1048575, 0, 1,
			ST_PLAN_DONE, FOOT_FREE, FOOT_ACCEL, 1, 102, 524287);
		// reversal mid-switch takes the time already spent
		add_row(ACT_PLAN, -65536, 1000, 3, 0, 1,
			ST_PLAN_DONE, FOOT_FREE, FOOT_BRAKE, 1, 0, 204);
		add_row(ACT_EXECUTE, 0, 5, 5, 0, 1, ST_CHANGING, FOOT_FREE, FOOT_BRAKE, 1, 0, 204);
		add_row(ACT_PLAN, -1, 9, 9, 0, 1, ST_PLAN_DONE, FOOT_FREE, FOOT_BRAKE, 1, 102, 204);
		add_row(ACT_PLAN, -1, 9, 9, 1, 1, ST_PLAN_DONE, FOOT_FREE, FOOT_BRAKE, 1, 204, 204);
		add_row(ACT_EXECUTE, 0, 0, 0, 0, 1, ST_CHANGED, FOOT_BRAKE, FOOT_BRAKE, 0, 0, 204);
		// from brake: keep, then neutral goes free with no time
		add_row(ACT_PLAN, -5, 40, 40, 0, 1, ST_PLAN_DONE, FOOT_BRAKE, FOOT_BRAKE, 0, 0, 204);
		add_row(ACT_PLAN, 0, 40, 40, 0, 1, ST_PLAN_DONE, FOOT_BRAKE, FOOT_FREE, 1, 0, 0);
		add_row(ACT_EXECUTE, 0, 0, 0, 0, 1, ST_CHANGED, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		// recognition hit while idle switches at once
		add_row(ACT_EXECUTE, 0, 0, 0, 1, 1, ST_IMMEDIATE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		// remaining rows go through the predictor
		add_row(ACT_PLAN, -1, 0, 0, 0, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_EXECUTE, 65535, 0, 0, 1, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_PLAN, 1, 0, 1048575, 0, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_EXECUTE, 0, 0, 0, 1, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_PLAN, 0, 0, 0, 0, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_EXECUTE, -65536, 1048575, 1048575, 0, 0,
			ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_PLAN, 65535, 1, 1, 0, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_EXECUTE, 0, 0, 0, 0, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_PLAN, 65535, 0, 0, 1, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_PLAN, -65536, 1048575, 0, 0, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_PLAN, 0, 3, 3, 0, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);
		add_row(ACT_EXECUTE, 0, 0, 0, 0, 0, ST_NO_CHANGE, FOOT_FREE, FOOT_FREE, 0, 0, 0);

		// register settings per phase, extremes first
		phase_resist = '{-65536, 65535, 0, 0, -65536, 65535, 137};
		phase_step = '{1, 65535, 0, 0, 65535, 1, 102};
		phase_resist[3] = int'($urandom_range(131071)) - 65536;
		phase_step[3] = $urandom_range(1, 65535);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_item(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_results();
			write_reg(REG_RESIST, phase_resist[ph]);
			write_reg(REG_STEP, phase_step[ph]);
			// one whole phase with no idling on either side
			quiet = (ph == 1);
			n = 0;
			while (n < PHASE_ITEMS) begin
				// hold the sender once until the block is empty
				if (ph == 3 && n >= PHASE_ITEMS / 2 && !paused) begin
					drain_results();
					paused = 1'b1;
				end
				if ($urandom_range(99) < 15) begin
					// noise: any field value
					it.action = action_t'($urandom_range(1));
					it.accel = ACCEL_W'($urandom());
					it.a2b = TIME_PORT_W'($urandom());
					it.b2a = TIME_PORT_W'($urandom());
					it.hit = $urandom_range(1);
					send_item(it, 1'b0, none);
					n++;
				end else begin
					// burst: plans in one direction, then executes
					dir = $urandom_range(99) < 40 ? 0 : ($urandom_range(99) < 67 ? 1 : 2);
					plans = $urandom_range(1, 20);
					execs = $urandom_range(1, 4);
					for (int k = 0; k < plans; k++) begin
						it.action = ACT_PLAN;
						it.accel = pick_accel(dir);
						it.a2b = pick_time();
						it.b2a = pick_time();
						it.hit = $urandom_range(1);
						send_item(it, 1'b0, none);
						n++;
					end
					for (int k = 0; k < execs; k++) begin
						it.action = ACT_EXECUTE;
						it.accel = ACCEL_W'($urandom());
						it.a2b = TIME_PORT_W'($urandom());
						it.b2a = TIME_PORT_W'($urandom());
						it.hit = ($urandom_range(99) < 30);
						send_item(it, 1'b0, none);
						n++;
					end
				end
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (err_count == 0 && pending_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/pdl_pkg.sv
rtl/core/pdl_cfg.sv
rtl/core/pdl_step.sv
rtl/core/driver_pedal_switch_fsm.sv
dv/driver_pedal_switch_fsm_tb.sv
